[hw/rtl/cse_pkg.sv]
// Shared types, constants and a saturation helper for the Chebyshev series evaluator.
package cse_pkg;

  localparam int XW   = 32;  // point / T value width, Q1.30
  localparam int CW   = 32;  // coefficient width, Q15.16
  localparam int SW   = 48;  // sum width, Q31.16
  localparam int PW   = XW + CW;

  localparam logic [1:0] BASIS_FULL = 2'd0;
  localparam logic [1:0] BASIS_EVEN = 2'd1;
  localparam logic [1:0] BASIS_ODD  = 2'd2;

  localparam logic signed [XW-1:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [PW-1:0] RND_REC   = 64'sd268435456;   // 2^28
  localparam logic signed [PW-1:0] RND_TERM  = 64'sd536870912;   // 2^29

  // shared multiplier request
  typedef struct packed {
    logic                   issue;
    logic signed [XW-1:0]   op_a;
    logic signed [CW-1:0]   op_b;
  } mul_req_t;

  // finished series result offered by the core
  typedef struct packed {
    logic                   valid;
    logic signed [SW-1:0]   sum;
    logic                   saturated;
  } res_t;

  function automatic logic signed [XW-1:0] sat32(input logic signed [XW+3:0] v);
    logic signed [XW+3:0] hi;
    logic signed [XW+3:0] lo;
    hi = 36'sh0_7FFF_FFFF;
    lo = -36'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[XW-1:0];
  endfunction

endpackage

[hw/rtl/cse_stream_if.sv]
// Valid/ready stream interfaces for coefficient input and series result output.
interface cse_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [cse_pkg::XW-1:0]   point;
  logic signed [cse_pkg::CW-1:0]   coefficient;
  logic                            last;

  modport source (output valid, point, coefficient, last, input ready);
  modport sink   (input valid, point, coefficient, last, output ready);
endinterface

interface cse_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cse_pkg::SW-1:0]   sum;
  logic                            saturated;

  modport source (output valid, sum, saturated, input ready);
  modport sink   (input valid, sum, saturated, output ready);
endinterface

[hw/rtl/cse_mul_unit.sv]
// Shared 32x32 signed multiplier with registered product.
module cse_mul_unit (
  input  logic                               clk,
  input  cse_pkg::mul_req_t                  req,
  output logic signed [cse_pkg::PW-1:0]      product
);

  logic signed [cse_pkg::PW-1:0] product_r;

  always_ff @(posedge clk) begin
    if (req.issue) begin
      product_r <= req.op_a * req.op_b;
    end
  end

  assign product = product_r;

endmodule

[hw/rtl/cse_core.sv]
// Sequencer and datapath: recurrence steps and accumulation on the shared multiplier.
module cse_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cse_pkg::XW-1:0]      in_point,
  input  logic signed [cse_pkg::CW-1:0]      in_coefficient,
  input  logic                               in_last,
  output cse_pkg::mul_req_t                  mul_req,
  input  logic signed [cse_pkg::PW-1:0]      mul_product,
  output cse_pkg::res_t                      res,
  input  logic                               res_take
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ADV     = 6'b000010,
    S_ADV_WB  = 6'b000100,
    S_TERM    = 6'b001000,
    S_TERM_WB = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [1:0]                     mode_r;
  logic                           in_series_r;
  logic                           second_r;
  logic                           last_r;
  logic signed [cse_pkg::CW-1:0]  coef_r;
  logic signed [cse_pkg::XW-1:0]  held_r;
  logic signed [cse_pkg::XW-1:0]  prev_r;
  logic signed [cse_pkg::XW-1:0]  cur_r;
  logic signed [cse_pkg::SW-1:0]  acc_r;
  logic                           ovf_r;

  logic                           in_fire;
  logic                           two_step;
  logic signed [cse_pkg::PW-1:0]  rec_rnd;
  logic signed [cse_pkg::PW-1:0]  term_rnd;
  logic signed [cse_pkg::XW+3:0]  rec_diff;
  logic signed [cse_pkg::XW-1:0]  rec_next;
  logic signed [cse_pkg::SW:0]    acc_sum;
  logic signed [cse_pkg::SW-1:0]  acc_next;
  logic                           acc_clip;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign two_step = (mode_r == cse_pkg::BASIS_EVEN) || (mode_r == cse_pkg::BASIS_ODD);

  // 2xT rounded to Q1.30, minus T(k-1), clipped to 32 bits
  assign rec_rnd  = mul_product + cse_pkg::RND_REC;
  assign rec_diff = {rec_rnd[cse_pkg::PW-1], rec_rnd[cse_pkg::PW-1:29]}
                    - {{4{prev_r[cse_pkg::XW-1]}}, prev_r};
  assign rec_next = cse_pkg::sat32(rec_diff);

  // coef x T rounded to Q31.16, saturating accumulate
  assign term_rnd = mul_product + cse_pkg::RND_TERM;
  assign acc_sum  = {acc_r[cse_pkg::SW-1], acc_r}
                    + {{15{term_rnd[cse_pkg::PW-1]}}, term_rnd[cse_pkg::PW-1:30]};

  always_comb begin
    acc_clip = 1'b0;
    acc_next = acc_sum[cse_pkg::SW-1:0];
    if (acc_sum[cse_pkg::SW] != acc_sum[cse_pkg::SW-1]) begin
      acc_clip = 1'b1;
      acc_next = acc_sum[cse_pkg::SW] ? {1'b1, {(cse_pkg::SW-1){1'b0}}}
                                      : {1'b0, {(cse_pkg::SW-1){1'b1}}};
    end
  end

  always_comb begin
    mul_req.issue = 1'b0;
    mul_req.op_a  = held_r;
    mul_req.op_b  = cur_r;
    case (state_r)
      S_ADV: begin
        mul_req.issue = 1'b1;
      end
      S_TERM: begin
        mul_req.issue = 1'b1;
        mul_req.op_a  = coef_r;
      end
      default: begin
        mul_req.issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_fire) state_nxt = in_series_r ? S_ADV : S_TERM;
      S_ADV:     state_nxt = S_ADV_WB;
      S_ADV_WB:  state_nxt = second_r ? S_ADV : S_TERM;
      S_TERM:    state_nxt = S_TERM_WB;
      S_TERM_WB: state_nxt = last_r ? S_OUT : S_IDLE;
      S_OUT:     if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= cse_pkg::BASIS_FULL;
      in_series_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        second_r <= in_series_r && two_step;
        in_series_r <= 1'b1;
      end else if (state_r == S_ADV_WB) begin
        second_r <= 1'b0;
      end else if (state_r == S_OUT && res_take) begin
        in_series_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          coef_r <= in_coefficient;
          last_r <= in_last;
          if (!in_series_r) begin
            held_r <= in_point;
            acc_r  <= '0;
            ovf_r  <= 1'b0;
            if (mode_r == cse_pkg::BASIS_ODD) begin
              prev_r <= cse_pkg::ONE_Q30;
              cur_r  <= in_point;
            end else begin
              prev_r <= in_point;
              cur_r  <= cse_pkg::ONE_Q30;
            end
          end
        end
      end
      S_ADV_WB: begin
        prev_r <= cur_r;
        cur_r  <= rec_next;
      end
      S_TERM_WB: begin
        acc_r <= acc_next;
        ovf_r <= ovf_r | acc_clip;
      end
      default: begin
      end
    endcase
  end

  assign res.valid     = (state_r == S_OUT);
  assign res.sum       = acc_r;
  assign res.saturated = ovf_r;

endmodule

[hw/rtl/chebyshev_series_eval_top.sv]
// Top level of the Chebyshev series evaluator: core, shared multiplier, output register.
//
// Usage:
//   in_chan  : one transaction per coefficient (Q15.16), lowest degree first.
//              point (Q1.30) is sampled on the first transaction of a series;
//              last marks the final coefficient.
//   out_chan : one transaction per series: the saturated Q31.16 sum and a flag
//              set if any accumulation of the series clipped at 48 bits.
//   cfg_wr_en / cfg_wr_data : basis_mode (full, even or odd degrees); write
//              only while the block is idle.
// Sequencing (all bound by the single 32x32 multiplier):
//   first coefficient of a series : one product, then ready again
//   later coefficient, full basis : one recurrence step + product
//   later coefficient, even / odd : two recurrence steps + product
//   After a last transaction the sum reaches the output register once the slot
//   is free; input reopens in that same cycle.
// in_chan.ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) returns to idle, clears out_chan.valid and sets
// the basis to full. If the receiver stalls, the result waits in the output
// register; a further series proceeds and only its own result waits for the slot.
module chebyshev_series_eval_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  cse_in_if.sink            in_chan,
  cse_out_if.source         out_chan
);

  cse_pkg::mul_req_t                  mul_req;
  logic signed [cse_pkg::PW-1:0]      mul_product;
  cse_pkg::res_t                      res;
  logic                               res_take;

  logic                               out_valid_r;
  logic signed [cse_pkg::SW-1:0]      out_sum_r;
  logic                               out_sat_r;

  cse_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_point       (in_chan.point),
    .in_coefficient (in_chan.coefficient),
    .in_last        (in_chan.last),
    .mul_req        (mul_req),
    .mul_product    (mul_product),
    .res            (res),
    .res_take       (res_take)
  );

  cse_mul_unit u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (mul_product)
  );

  // output slot frees when empty or when its transaction completes
  assign res_take = res.valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_sum_r <= res.sum;
      out_sat_r <= res.saturated;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.sum       = out_sum_r;
  assign out_chan.saturated = out_sat_r;

endmodule

[hw/rtl/cse_checker.sv]
// Port-level checker for the Chebyshev series evaluator, bound to the top level.
module cse_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [cse_pkg::SW-1:0]  out_sum,
  input  logic                           out_saturated
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_saturated))
    else $error("result changed while stalled");

  // one coefficient at a time: busy right after a transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after input transaction");

  // a result never appears right after an input transaction
  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too soon after input");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind chebyshev_series_eval_top cse_checker u_cse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_sum       (out_chan.sum),
  .out_saturated (out_chan.saturated)
);
